### hdl/apfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// apfs_pkg
// Shared constants, types and helper functions for the partition function
// sum block.
// ---------------------------------------------------------------------------
package apfs_pkg;

  // default widths of the parameterized fields
  localparam int ENERGY_BITS_DEF = 24;
  localparam int SUM_BITS_DEF    = 48;
  localparam int ION_BITS_DEF    = 10;
  localparam int QUEUE_DEPTH     = 4;

  // fixed field widths
  localparam int TEMP_BITS = 24;
  localparam int RW_BITS   = 18;
  localparam int DEG_BITS  = 12;
  localparam int FRAC_BITS = 16;
  localparam int TERM_BITS = 64;
  localparam int RWG_BITS  = RW_BITS + DEG_BITS;

  // configuration port
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;
  localparam logic REG_TEMPERATURE = 1'b0;
  localparam logic REG_RAD_WEIGHT  = 1'b1;
  localparam logic [TEMP_BITS-1:0] TEMP_RESET = 24'd10000;
  localparam logic [RW_BITS-1:0]   RW_RESET   = 18'd65536;

  // log2(e) / k_B in Q.16 (per meV per kelvin), and ln2 in Q0.32
  localparam int CLOG_BITS = 21;
  localparam logic [CLOG_BITS-1:0] CLOG_Q16 = 21'd1097189;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // Taylor series length and reciprocal scale for the divide by k
  localparam logic [3:0] SERIES_TERMS = 4'd12;
  localparam int RECIP_SHIFT = 35;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic start;
    logic grow;
  } term_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } term_stat_t;

  // all ones in the low bits positions of a 64-bit word
  function automatic logic [TERM_BITS-1:0] sum_max(input int bits);
    logic [TERM_BITS-1:0] m;
    if (bits >= TERM_BITS) begin
      m = '1;
    end else begin
      m = (64'd1 << bits) - 64'd1;
    end
    return m;
  endfunction

  // floor(2^35 / k) for the series divisors
  function automatic logic [RECIP_SHIFT:0] recip(input logic [3:0] k);
    logic [RECIP_SHIFT:0] r;
    case (k)
      4'd1:    r = 36'd34359738368;
      4'd2:    r = 36'd17179869184;
      4'd3:    r = 36'd11453246122;
      4'd4:    r = 36'd8589934592;
      4'd5:    r = 36'd6871947673;
      4'd6:    r = 36'd5726623061;
      4'd7:    r = 36'd4908534052;
      4'd8:    r = 36'd4294967296;
      4'd9:    r = 36'd3817748707;
      4'd10:   r = 36'd3435973836;
      4'd11:   r = 36'd3123612578;
      4'd12:   r = 36'd2863311530;
      default: r = 36'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/apfs_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// apfs_fifo
// Short register queue between the classifying front and the compute back.
// ---------------------------------------------------------------------------
module apfs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = apfs_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output apfs_pkg::q_stat_t     stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;

  assign dout       = mem[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == (AW+1)'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

### hdl/apfs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// apfs_front
// Takes level words, tracks the ground energy and queues each level with
// its energy offset and direction.
// ---------------------------------------------------------------------------
module apfs_front #(
  parameter int ENERGY_BITS    = apfs_pkg::ENERGY_BITS_DEF,
  parameter int ION_INDEX_BITS = apfs_pkg::ION_BITS_DEF,
  parameter int QW             = ION_INDEX_BITS + ENERGY_BITS + apfs_pkg::DEG_BITS + 3
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ION_INDEX_BITS-1:0]     ion_number,
  input  wire logic                          first_level,
  input  wire logic                          last_level,
  input  wire logic [apfs_pkg::DEG_BITS-1:0] degeneracy,
  input  wire logic [ENERGY_BITS-1:0]        level_energy,
  input  apfs_pkg::q_stat_t                  q_stat,
  output logic                               push,
  output logic [QW-1:0]                      din
);

  logic [ENERGY_BITS-1:0] ground_energy;
  logic                   grow;
  logic [ENERGY_BITS-1:0] diff;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    grow = level_energy < ground_energy;
    diff = grow ? ground_energy - level_energy : level_energy - ground_energy;
    din  = {ion_number, first_level, last_level, degeneracy, grow, diff};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ground_energy <= '0;
    end else if (push && first_level) begin
      ground_energy <= level_energy;
    end
  end

endmodule
`default_nettype wire

### hdl/apfs_term.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// apfs_term
// Iterative unit for one excited level: w*g*exp(-d/kT) in Q.16, or w*g*exp(+d/kT)
// for a level below the ground (grow). Restoring divide (one bit a cycle),
// 12-term series (multiply, divide and fix steps per term), split product and final scale shift.
// ---------------------------------------------------------------------------
module apfs_term #(
  parameter int ENERGY_BITS = apfs_pkg::ENERGY_BITS_DEF,
  parameter int SUM_BITS    = apfs_pkg::SUM_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  apfs_pkg::term_req_t                 req,
  input  wire logic [apfs_pkg::DEG_BITS-1:0]  g,
  input  wire logic [ENERGY_BITS-1:0]         d,
  input  wire logic [apfs_pkg::TEMP_BITS-1:0] temperature,
  input  wire logic [apfs_pkg::RW_BITS-1:0]   radiation_weight,
  output apfs_pkg::term_stat_t                stat,
  output logic [apfs_pkg::TERM_BITS-1:0]      term
);

  localparam int DW = ENERGY_BITS + apfs_pkg::CLOG_BITS;
  localparam int NW = DW - apfs_pkg::FRAC_BITS;
  localparam int CW = $clog2(DW + 1);
  localparam int TB = apfs_pkg::TEMP_BITS;
  localparam int RGB = apfs_pkg::RWG_BITS;
  localparam logic [63:0] SUM_MAX64 = apfs_pkg::sum_max(SUM_BITS);

  typedef enum logic [10:0] {
    T_IDLE  = 11'b00000000001,
    T_DIV   = 11'b00000000010,
    T_PREP  = 11'b00000000100,
    T_ZMUL  = 11'b00000001000,
    T_TMUL  = 11'b00000010000,
    T_TDIV  = 11'b00000100000,
    T_TFIX  = 11'b00001000000,
    T_MANT  = 11'b00010000000,
    T_PLO   = 11'b00100000000,
    T_PHI   = 11'b01000000000,
    T_SHIFT = 11'b10000000000
  } tstate_t;

  tstate_t          state;
  logic [CW-1:0]    cnt;
  logic [DW-1:0]    quo;
  logic [TB-1:0]    rem;
  logic [TB-1:0]    dvs;
  logic             grow_r;
  logic [RGB-1:0]   rwg;
  logic             zero_r;
  logic             big_r;
  logic             left_r;
  logic [6:0]       shamt;
  logic [15:0]      ef;
  logic [31:0]      z;
  logic [32:0]      tk;
  logic [31:0]      x;
  logic [31:0]      q0;
  logic [3:0]       k;
  logic [33:0]      pos;
  logic [33:0]      neg;
  logic [32:0]      mant;
  logic [RGB+15:0]  plo;
  logic [63:0]      p;

  logic [TB:0]      rem_sh;
  logic             div_ge;
  logic [TB-1:0]    rem_new;
  logic [NW-1:0]    n_w;
  logic [15:0]      f_w;
  logic [NW:0]      s_w;
  logic [NW:0]      sh_w;
  logic [47:0]      zprod;
  logic [64:0]      txz;
  logic [67:0]      xr;
  logic [35:0]      qk;
  logic [35:0]      r_w;
  logic [31:0]      tnext;
  logic [RGB+15:0]  plo_w;
  logic [RGB+16:0]  phi_w;
  logic [63:0]      right_w;
  logic [63:0]      left_w;
  logic [63:0]      lim_w;

  always_comb begin
    rem_sh  = {rem, quo[DW-1]};
    div_ge  = rem_sh >= {1'b0, dvs};
    rem_new = div_ge ? TB'(rem_sh - {1'b0, dvs}) : rem_sh[TB-1:0];
    n_w     = quo[DW-1:apfs_pkg::FRAC_BITS];
    f_w     = quo[apfs_pkg::FRAC_BITS-1:0];
    s_w     = {1'b0, n_w} + (NW+1)'(f_w != 16'd0);
    sh_w    = s_w - (NW+1)'(32);
    zprod   = 48'(ef) * 48'(apfs_pkg::LN2_Q32);
    txz     = 65'(tk) * 65'(z);
    xr      = 68'(x) * 68'(apfs_pkg::recip(k));
    qk      = 36'(q0) * 36'(k);
    r_w     = 36'(x) - qk;
    tnext   = (r_w >= 36'(k)) ? q0 + 32'd1 : q0;
    plo_w   = (RGB+16)'(rwg) * (RGB+16)'(mant[15:0]);
    phi_w   = (RGB+17)'(rwg) * (RGB+17)'(mant[32:16]);
    right_w = p >> shamt;
    left_w  = p << shamt[5:0];
    lim_w   = SUM_MAX64 >> shamt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      stat.done <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      unique case (state)
        T_IDLE: begin
          if (req.start) begin
            quo    <= DW'(d) * DW'(apfs_pkg::CLOG_Q16);
            dvs    <= (temperature == '0) ? TB'(1) : temperature;
            rem    <= '0;
            cnt    <= CW'(DW);
            rwg    <= RGB'(radiation_weight) * RGB'(g);
            grow_r <= req.grow;
            state  <= T_DIV;
          end
        end
        T_DIV: begin
          quo <= {quo[DW-2:0], div_ge};
          rem <= rem_new;
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= T_PREP;
          end
        end
        T_PREP: begin
          zero_r <= 1'b0;
          big_r  <= 1'b0;
          left_r <= 1'b0;
          ef     <= grow_r ? 16'(17'h10000 - 17'(f_w)) : f_w;
          if (!grow_r) begin
            shamt <= 7'd32 + 7'(n_w[4:0]);
            if (n_w >= NW'(32)) begin
              zero_r <= 1'b1;
            end
          end else if (s_w <= (NW+1)'(32)) begin
            shamt <= 7'((NW+1)'(32) - s_w);
          end else begin
            shamt  <= 7'(sh_w[5:0]);
            left_r <= 1'b1;
            big_r  <= (sh_w >= (NW+1)'(64));
          end
          if (!grow_r && n_w >= NW'(32)) begin
            state <= T_SHIFT;
          end else if (grow_r && f_w == 16'd0) begin
            mant  <= 33'h1_0000_0000;
            state <= T_PLO;
          end else begin
            state <= T_ZMUL;
          end
        end
        T_ZMUL: begin
          z     <= zprod[47:16];
          tk    <= 33'h1_0000_0000;
          pos   <= 34'h1_0000_0000;
          neg   <= '0;
          k     <= 4'd1;
          state <= T_TMUL;
        end
        T_TMUL: begin
          x     <= txz[63:32];
          state <= T_TDIV;
        end
        T_TDIV: begin
          q0    <= xr[66:apfs_pkg::RECIP_SHIFT];
          state <= T_TFIX;
        end
        T_TFIX: begin
          tk <= {1'b0, tnext};
          if (k[0]) begin
            neg <= neg + 34'(tnext);
          end else begin
            pos <= pos + 34'(tnext);
          end
          k <= k + 4'd1;
          state <= (k == apfs_pkg::SERIES_TERMS) ? T_MANT : T_TMUL;
        end
        T_MANT: begin
          mant  <= 33'(pos - neg);
          state <= T_PLO;
        end
        T_PLO: begin
          plo   <= plo_w;
          state <= T_PHI;
        end
        T_PHI: begin
          p     <= 64'(plo) + (64'(phi_w) << 16);
          state <= T_SHIFT;
        end
        T_SHIFT: begin
          stat.done <= 1'b1;
          stat.sat  <= 1'b0;
          if (zero_r || p == '0) begin
            term <= '0;
          end else if (big_r) begin
            term     <= SUM_MAX64;
            stat.sat <= 1'b1;
          end else if (!left_r) begin
            term <= right_w;
          end else if (p > lim_w) begin
            term     <= SUM_MAX64;
            stat.sat <= 1'b1;
          end else begin
            term <= left_w;
          end
          state <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/apfs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// apfs_back
// Pops queued levels, runs the term unit, keeps the saturating sum and
// holds the result word until it is taken.
// ---------------------------------------------------------------------------
module apfs_back #(
  parameter int ENERGY_BITS    = apfs_pkg::ENERGY_BITS_DEF,
  parameter int SUM_BITS       = apfs_pkg::SUM_BITS_DEF,
  parameter int ION_INDEX_BITS = apfs_pkg::ION_BITS_DEF,
  parameter int QW             = ION_INDEX_BITS + ENERGY_BITS + apfs_pkg::DEG_BITS + 3
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [QW-1:0]                 head,
  input  apfs_pkg::q_stat_t                  q_stat,
  output logic                               pop,
  output apfs_pkg::term_req_t                req,
  output logic [apfs_pkg::DEG_BITS-1:0]      g,
  output logic [ENERGY_BITS-1:0]             d,
  input  apfs_pkg::term_stat_t               tstat,
  input  wire logic [apfs_pkg::TERM_BITS-1:0] term,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ION_INDEX_BITS-1:0]          result_ion,
  output logic [SUM_BITS-1:0]                partition_value,
  output logic                               overflowed
);

  localparam int EB = ENERGY_BITS;
  localparam int GB = apfs_pkg::DEG_BITS;
  localparam logic [63:0] SUM_MAX64 = apfs_pkg::sum_max(SUM_BITS);

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_WAIT = 2'b10
  } bstate_t;

  bstate_t                   state;
  logic [SUM_BITS-1:0]       running_sum;
  logic                      saturated_mark;
  logic [ION_INDEX_BITS-1:0] ion_r;
  logic                      last_r;

  logic [ION_INDEX_BITS-1:0] h_ion;
  logic                      h_first;
  logic                      h_last;
  logic                      out_free;
  logic [63:0]               room;
  logic [SUM_BITS-1:0]       sum_next;
  logic                      mark_next;
  logic                      emit;
  logic [ION_INDEX_BITS-1:0] emit_ion;

  always_comb begin
    d        = head[EB-1:0];
    req.grow = head[EB];
    g        = head[EB+GB:EB+1];
    h_last   = head[EB+GB+1];
    h_first  = head[EB+GB+2];
    h_ion    = head[QW-1:EB+GB+3];

    out_free  = !out_valid || !out_stall;
    pop       = !q_stat.empty && (state == B_IDLE) && (!h_last || out_free);
    req.start = pop && !h_first;

    room      = SUM_MAX64 - 64'(running_sum);
    sum_next  = running_sum;
    mark_next = saturated_mark;
    emit      = 1'b0;
    emit_ion  = h_ion;
    if (pop && h_first) begin
      // ground level loads its own weight
      sum_next  = SUM_BITS'(g) << 16;
      mark_next = 1'b0;
      emit      = h_last;
    end else if (state == B_WAIT && tstat.done) begin
      if (tstat.sat || term > room) begin
        sum_next  = SUM_BITS'(SUM_MAX64);
        mark_next = 1'b1;
      end else begin
        sum_next = running_sum + term[SUM_BITS-1:0];
      end
      emit     = last_r;
      emit_ion = ion_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= B_IDLE;
      running_sum    <= '0;
      saturated_mark <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      running_sum    <= sum_next;
      saturated_mark <= mark_next;
      unique case (state)
        B_IDLE: begin
          if (req.start) begin
            state <= B_WAIT;
          end
        end
        B_WAIT: begin
          if (tstat.done) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ion_r  <= h_ion;
      last_r <= h_last;
    end
    if (emit) begin
      result_ion      <= emit_ion;
      partition_value <= sum_next;
      overflowed      <= mark_next;
    end
  end

endmodule
`default_nettype wire

### hdl/atomic_partition_function_sum.sv
`timescale 1ns / 1ps
`default_nettype none
// A ground level goes from the queue head straight to the output register; an excited level
//   runs through the bit-serial divider and the 12-term exp series in the term unit, and
//   no new level is taken from the queue until that term is summed. Ground levels one per
//   cycle while the term unit is idle and, for a last level, while the output register is free.
// Reset: synchronous; empties the queue, clears the sum, flag and ground energy,
//   sets temperature to 10000 K and the excited weight to one.
// ---------------------------------------------------------------------------
// atomic_partition_function_sum
// Streams atomic levels ion by ion and returns one weighted Boltzmann
// partition function per ion.
// ---------------------------------------------------------------------------
module atomic_partition_function_sum #(
  parameter int ENERGY_BITS    = apfs_pkg::ENERGY_BITS_DEF,
  parameter int SUM_BITS       = apfs_pkg::SUM_BITS_DEF,
  parameter int ION_INDEX_BITS = apfs_pkg::ION_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [apfs_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [apfs_pkg::DATA_BITS-1:0] pwdata,
  output logic      [apfs_pkg::DATA_BITS-1:0] prdata,
  output logic                                pready,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [ION_INDEX_BITS-1:0]      ion_number,
  input  wire logic                           first_level,
  input  wire logic                           last_level,
  input  wire logic [apfs_pkg::DEG_BITS-1:0]  degeneracy,
  input  wire logic [ENERGY_BITS-1:0]         level_energy,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [ION_INDEX_BITS-1:0]           result_ion,
  output logic [SUM_BITS-1:0]                 partition_value,
  output logic                                overflowed
);

  localparam int QW = ION_INDEX_BITS + ENERGY_BITS + apfs_pkg::DEG_BITS + 3;

  logic [apfs_pkg::TEMP_BITS-1:0] temperature;
  logic [apfs_pkg::RW_BITS-1:0]   radiation_weight;
  logic                           reg_sel;

  apfs_pkg::q_stat_t              q_stat;
  apfs_pkg::term_req_t            req;
  apfs_pkg::term_stat_t           tstat;
  logic                           push;
  logic                           pop;
  logic [QW-1:0]                  din;
  logic [QW-1:0]                  head;
  logic [apfs_pkg::DEG_BITS-1:0]  t_g;
  logic [ENERGY_BITS-1:0]         t_d;
  logic [apfs_pkg::TERM_BITS-1:0] term;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_comb begin
    unique case (reg_sel)
      apfs_pkg::REG_TEMPERATURE: prdata = apfs_pkg::DATA_BITS'(temperature);
      apfs_pkg::REG_RAD_WEIGHT:  prdata = apfs_pkg::DATA_BITS'(radiation_weight);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      temperature      <= apfs_pkg::TEMP_RESET;
      radiation_weight <= apfs_pkg::RW_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        apfs_pkg::REG_TEMPERATURE:
          temperature <= pwdata[apfs_pkg::TEMP_BITS-1:0];
        apfs_pkg::REG_RAD_WEIGHT:
          radiation_weight <= pwdata[apfs_pkg::RW_BITS-1:0];
        default: ;
      endcase
    end
  end

  apfs_front #(
    .ENERGY_BITS(ENERGY_BITS),
    .ION_INDEX_BITS(ION_INDEX_BITS),
    .QW(QW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .ion_number(ion_number),
    .first_level(first_level),
    .last_level(last_level),
    .degeneracy(degeneracy),
    .level_energy(level_energy),
    .q_stat(q_stat),
    .push(push),
    .din(din)
  );

  apfs_fifo #(
    .WIDTH(QW),
    .DEPTH(apfs_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .din(din),
    .pop(pop),
    .dout(head),
    .stat(q_stat)
  );

  apfs_term #(
    .ENERGY_BITS(ENERGY_BITS),
    .SUM_BITS(SUM_BITS)
  ) u_term (
    .clk(clk),
    .rst(rst),
    .req(req),
    .g(t_g),
    .d(t_d),
    .temperature(temperature),
    .radiation_weight(radiation_weight),
    .stat(tstat),
    .term(term)
  );

  apfs_back #(
    .ENERGY_BITS(ENERGY_BITS),
    .SUM_BITS(SUM_BITS),
    .ION_INDEX_BITS(ION_INDEX_BITS),
    .QW(QW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .q_stat(q_stat),
    .pop(pop),
    .req(req),
    .g(t_g),
    .d(t_d),
    .tstat(tstat),
    .term(term),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_ion(result_ion),
    .partition_value(partition_value),
    .overflowed(overflowed)
  );

endmodule
`default_nettype wire

### hdl/apfs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// apfs_checker
// Port-level checks on the partition function sum block.
// ---------------------------------------------------------------------------
module apfs_checker #(
  parameter int ENERGY_BITS    = apfs_pkg::ENERGY_BITS_DEF,
  parameter int SUM_BITS       = apfs_pkg::SUM_BITS_DEF,
  parameter int ION_INDEX_BITS = apfs_pkg::ION_BITS_DEF
) (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           psel,
  input wire logic                           penable,
  input wire logic                           pwrite,
  input wire logic [apfs_pkg::ADDR_BITS-1:0] paddr,
  input wire logic [apfs_pkg::DATA_BITS-1:0] pwdata,
  input wire logic [apfs_pkg::DATA_BITS-1:0] prdata,
  input wire logic                           pready,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic [ION_INDEX_BITS-1:0]      ion_number,
  input wire logic                           first_level,
  input wire logic                           last_level,
  input wire logic [apfs_pkg::DEG_BITS-1:0]  degeneracy,
  input wire logic [ENERGY_BITS-1:0]         level_energy,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [ION_INDEX_BITS-1:0]      result_ion,
  input wire logic [SUM_BITS-1:0]            partition_value,
  input wire logic                           overflowed
);

  // a saturated sum never leaves the top of its range
  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflowed |-> (&partition_value))
    else $error("overflowed word without saturated value");

  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present after reset");

  // queue is empty after reset, so input is open
  a_rst_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(partition_value)
      && $stable(result_ion) && $stable(overflowed))
    else $error("stalled result word changed");

endmodule

bind atomic_partition_function_sum apfs_checker #(
  .ENERGY_BITS(ENERGY_BITS),
  .SUM_BITS(SUM_BITS),
  .ION_INDEX_BITS(ION_INDEX_BITS)
) u_apfs_checker (.*);
`default_nettype wire

### tb/sv/tb_atomic_partition_function_sum.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_atomic_partition_function_sum
// Self-checking bench for the partition function sum block. Level words
// are queued by phase under several temperature and weight settings. A
// clocked driver sends them in random bursts, and a bit-accurate
// fixed-point predictor builds the expected per-ion sums. A monitor
// compares each result word against the oldest expected sum.
// ---------------------------------------------------------------------------
module tb_atomic_partition_function_sum;

  localparam int CLK_HALF   = 6;
  localparam int IDLE_DRAIN = 500;   // covers a full queue of excited levels
  localparam int WDOG_LIMIT = 6000;
  localparam logic [63:0] SUM_TOP = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] Q32_ONE = 64'h1_0000_0000;

  typedef struct packed {
    logic [9:0]  ion;
    logic        first;
    logic        last;
    logic [11:0] deg;
    logic [23:0] energy;
  } level_word_t;

  typedef struct packed {
    logic [9:0]  ion;
    logic [47:0] value;
    logic        ovf;
  } ion_sum_t;

  logic clk = 1'b0, rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [apfs_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [apfs_pkg::DATA_BITS-1:0] pwdata = '0;
  logic [apfs_pkg::DATA_BITS-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_stall;
  logic [9:0] ion_number = '0;
  logic first_level = 1'b0, last_level = 1'b0;
  logic [11:0] degeneracy = '0;
  logic [23:0] level_energy = '0;
  logic out_valid, out_stall = 1'b0, overflowed;
  logic [9:0] result_ion;
  logic [47:0] partition_value;

  atomic_partition_function_sum uut (.*);

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  level_word_t pending_levels[$];
  ion_sum_t    expected_sums[$];

  // predictor state
  logic [63:0] temp_k, rad_weight, ground_e, run_sum;
  logic        sat_mark;

  int mismatches = 0, results_seen = 0, levels_sent = 0, sat_results = 0;
  int idle_cycles = 0;
  bit hold_sender = 1'b0;

  // 2^(-f/65536) in Q0.32 by a 12-term series of exp(-f*ln2)
  function automatic logic [63:0] exp2_neg_frac(input logic [63:0] f);
    logic [63:0] z, t, pos, neg;
    z = ((f & 64'hFFFF) * 64'd2977044472) >> 16;
    t = Q32_ONE;
    pos = Q32_ONE;
    neg = 0;
    for (int k = 1; k <= 12; k++) begin
      t = ((t * z) >> 32) / k;
      if (k % 2) neg += t;
      else pos += t;
    end
    return pos - neg;
  endfunction

  function automatic logic [63:0] boltzmann_term(input logic [63:0] g, input logic [63:0] e,
                                                 output logic sat);
    logic grow;
    logic [63:0] d, t, y, n, f, p, mant, s;
    sat = 1'b0;
    grow = e < ground_e;
    d = grow ? ground_e - e : e - ground_e;
    t = (temp_k != 0) ? temp_k : 64'd1;
    y = (d * 64'd1097189) / t;
    n = y >> 16;
    f = y & 64'hFFFF;
    if (!grow) begin
      if (n >= 32) return 0;
      p = rad_weight * g * exp2_neg_frac(f);
      return p >> (32 + n);
    end
    if (f == 0) begin
      mant = Q32_ONE;
      s = n;
    end else begin
      mant = exp2_neg_frac(64'd65536 - f);
      s = n + 1;
    end
    p = rad_weight * g * mant;
    if (p == 0) return 0;
    if (s <= 32) return p >> (32 - s);
    s -= 32;
    if (s >= 64 || p > (SUM_TOP >> s)) begin
      sat = 1'b1;
      return SUM_TOP;
    end
    return p << s;
  endfunction

  task automatic accumulate_level(input level_word_t w);
    logic [63:0] term;
    logic sat;
    ion_sum_t r;
    if (w.first) begin
      ground_e = 64'(w.energy);
      run_sum = 64'({w.deg, 16'd0});
      sat_mark = 1'b0;
    end else begin
      term = boltzmann_term(64'(w.deg), 64'(w.energy), sat);
      if (sat || term > SUM_TOP - run_sum) begin
        run_sum = SUM_TOP;
        sat_mark = 1'b1;
      end else begin
        run_sum += term;
      end
    end
    if (w.last) begin
      r.ion = w.ion;
      r.value = run_sum[47:0];
      r.ovf = sat_mark;
      expected_sums.push_back(r);
    end
  endtask

  // sender: bursts and gaps, payload held while stalled
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
      // hold current word
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else if (pending_levels.size() > 0 && !hold_sender) begin
      level_word_t w;
      w = pending_levels.pop_front();
      {ion_number, first_level, last_level, degeneracy, level_energy} <= w;
      in_valid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 12);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver stall pattern, drawn from four stall modes picked at random
  int stall_mode = 0, stall_tick = 0;
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      2: out_stall <= (stall_tick % 24) < 16;
      default: out_stall <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // acceptance, prediction, checking, watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        accumulate_level({ion_number, first_level, last_level, degeneracy, level_energy});
        levels_sent++;
      end
      if (out_valid && !out_stall) begin
        ion_sum_t e;
        results_seen++;
        if (overflowed) sat_results++;
        if (expected_sums.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected sum word: ion %0d value %h ovf %0b",
                     result_ion, partition_value, overflowed);
        end else begin
          e = expected_sums.pop_front();
          if (e.ion !== result_ion || e.value !== partition_value || e.ovf !== overflowed) begin
            mismatches++;
            if (mismatches <= 10)
              $display("sum mismatch: exp ion %0d value %h ovf %0b, got ion %0d value %h ovf %0b",
                       e.ion, e.value, e.ovf, result_ion, partition_value, overflowed);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("[atomic_partition_function_sum] ERROR");
        $finish;
      end
    end
  end

  task automatic add_level(input int ion, input bit first, input bit last, input int g,
                           input logic [23:0] e);
    level_word_t w;
    w.ion = 10'(ion);
    w.first = first;
    w.last = last;
    w.deg = 12'(g);
    w.energy = e;
    pending_levels.push_back(w);
  endtask

  task automatic wait_idle();
    while (pending_levels.size() > 0 || in_valid || expected_sums.size() > 0) @(posedge clk);
    repeat (IDLE_DRAIN) @(posedge clk);
  endtask

  task automatic reg_write(input logic reg_sel, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_sel == apfs_pkg::REG_TEMPERATURE) temp_k = 64'(value & 32'hFFFFFF);
    else rad_weight = 64'(value & 32'h3FFFF);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // one ion: ground level plus excited levels near or far from it
  task automatic add_ion(input int n_exc);
    int ion;
    logic [23:0] e0, e;
    ion = $urandom_range(0, 1023);
    e0 = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 20000));
    add_level(ion, 1, n_exc == 0, $urandom_range(0, 4095), e0);
    for (int i = 1; i <= n_exc; i++) begin
      case ($urandom_range(0, 7))
        0: e = 24'($urandom);
        1: e = e0 - 24'($urandom_range(0, 3000));
        default: e = e0 + 24'($urandom_range(0, 4000));
      endcase
      add_level(ion, 0, i == n_exc, $urandom_range(0, 4095), e);
    end
  endtask

  task automatic random_phase(input int n_items);
    int start;
    start = pending_levels.size();
    while (pending_levels.size() - start < n_items) begin
      if ($urandom_range(0, 9) == 0)
        add_level($urandom_range(0, 1023), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), $urandom_range(0, 4095), 24'($urandom));
      else
        add_ion($urandom_range(0, 5));
    end
  endtask

  initial begin
    temp_k = 64'(apfs_pkg::TEMP_RESET);
    rad_weight = 64'(apfs_pkg::RW_RESET);
    ground_e = 0;
    run_sum = 0;
    sat_mark = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: missing ground level, lone ground levels, extremes
    hold_sender = 1'b1;
    add_level(3, 0, 0, 100, 24'd500);
    add_level(3, 0, 1, 4095, 24'd0);
    add_level(1023, 1, 1, 4095, 24'hFFFFFF);
    add_level(0, 1, 1, 0, 24'd0);
    add_level(7, 1, 0, 2, 24'd1000);
    add_level(7, 0, 0, 4095, 24'd1000);
    add_level(7, 0, 0, 4095, 24'd1800);
    add_level(7, 0, 0, 1, 24'hFFFFFF);
    add_level(9, 0, 1, 10, 24'd200);
    add_level(5, 1, 0, 1, 24'hFFFFFF);
    add_level(5, 0, 1, 4095, 24'd0);
    add_level(6, 1, 0, 1, 24'd2000);
    add_level(6, 0, 0, 4095, 24'd1990);
    add_level(6, 0, 1, 4095, 24'd1500);
    add_level(8, 1, 0, 5, 24'd100);
    add_level(8, 0, 0, 5, 24'd200);
    hold_sender = 1'b0;
    wait_idle();

    reg_write(apfs_pkg::REG_TEMPERATURE, 32'd1);
    reg_write(apfs_pkg::REG_RAD_WEIGHT, 32'd131072);
    add_level(2, 1, 0, 4095, 24'd10);
    add_level(2, 0, 0, 4095, 24'd9);
    add_level(2, 0, 1, 4095, 24'd0);
    random_phase(150);
    wait_idle();

    reg_write(apfs_pkg::REG_TEMPERATURE, 32'hFFFFFF);
    reg_write(apfs_pkg::REG_RAD_WEIGHT, 32'h3FFFF);
    random_phase(250);
    wait_idle();

    reg_write(apfs_pkg::REG_TEMPERATURE, 32'd0);
    reg_write(apfs_pkg::REG_RAD_WEIGHT, 32'd0);
    random_phase(150);
    wait_idle();

    reg_write(apfs_pkg::REG_TEMPERATURE, 32'd10000);
    reg_write(apfs_pkg::REG_RAD_WEIGHT, 32'd65536);
    random_phase(400);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      reg_write(apfs_pkg::REG_TEMPERATURE, $urandom_range(1000, 200000));
      reg_write(apfs_pkg::REG_RAD_WEIGHT, $urandom_range(0, 131072));
      random_phase(210);
      wait_idle();
    end

    $display("covered %0d level words and %0d ion sums (%0d saturated)",
             levels_sent, results_seen, sat_results);
    $display("register settings swept over temperature and weight extremes");
    if (mismatches == 0) begin
      $display("[atomic_partition_function_sum] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[atomic_partition_function_sum] ERROR");
    end
    $finish;
  end

endmodule
